>>> hdl/assert_macros.svh
// Assertion macros used by the decoder back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define U8SD_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// A consequent that must hold in the same cycle as its antecedent.
`define U8SD_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// A consequent that must hold in the cycle after its antecedent.
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> hdl/u8sd_pkg.sv
// Shared types and constants of the UTF-8 stream decoder.
package u8sd_pkg;

  localparam int BYTE_W     = 8;
  localparam int CP_W       = 21;
  localparam int ST_W       = 2;
  localparam int KIND_W     = 3;
  localparam int BLEFT_W    = 2;
  localparam int CONT_BITS  = 6;
  localparam int OUT_DATA_W = 24;

  // Byte classes found by the front end.
  typedef logic [KIND_W-1:0] kind_t;
  localparam kind_t K_TERM  = 3'd0;
  localparam kind_t K_ASCII = 3'd1;
  localparam kind_t K_LEAD2 = 3'd2;
  localparam kind_t K_LEAD3 = 3'd3;
  localparam kind_t K_LEAD4 = 3'd4;
  localparam kind_t K_BAD   = 3'd5;

  // Result status codes.
  typedef logic [ST_W-1:0] status_t;
  localparam status_t ST_COMPLETE  = 2'd0;
  localparam status_t ST_TRUNCATED = 2'd1;
  localparam status_t ST_BAD_LEAD  = 2'd2;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
  } token_t;

  typedef struct packed {
    logic   valid;
    token_t token;
  } push_t;

endpackage

>>> hdl/u8sd_front.sv
// Front end: accepts input bytes and classifies them by their leading ones.
module u8sd_front (
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [u8sd_pkg::BYTE_W-1:0] s_tdata,
  input  logic                       q_full,
  output u8sd_pkg::push_t            push
);
  import u8sd_pkg::*;

  kind_t kind;

  // Count of leading ones decides the class; a zero byte is the terminator.
  always_comb begin
    priority casez (s_tdata)
      8'b0000_0000: kind = K_TERM;
      8'b0???_????: kind = K_ASCII;
      8'b10??_????: kind = K_BAD;
      8'b110?_????: kind = K_LEAD2;
      8'b1110_????: kind = K_LEAD3;
      8'b1111_0???: kind = K_LEAD4;
      default:      kind = K_BAD;
    endcase
  end

  // A transaction completes whenever the queue has room.
  assign s_tready         = !q_full;
  assign push.valid       = s_tvalid && !q_full;
  assign push.token.kind  = kind;
  assign push.token.data  = s_tdata;

endmodule

>>> hdl/u8sd_queue.sv
// Short token queue between the front end and the back end.
module u8sd_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  u8sd_pkg::push_t   push,
  output logic              full,
  input  logic              pop,
  output logic              tok_valid,
  output u8sd_pkg::token_t  tok
);
  import u8sd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  token_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign tok_valid = (count != '0);
  assign tok       = slots[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && tok_valid;

  // Storage for queued tokens.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.token;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/u8sd_back.sv
// Back end: sequence state, code point accumulation and the output register.
`include "assert_macros.svh"

module u8sd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           tok_valid,
  input  u8sd_pkg::token_t               tok,
  output logic                           pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [u8sd_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [u8sd_pkg::ST_W-1:0]       m_tuser
);
  import u8sd_pkg::*;

  logic [BLEFT_W-1:0] bytes_left;
  logic [BLEFT_W-1:0] bytes_left_next;
  logic [CP_W-1:0]    accumulator;
  logic [CP_W-1:0]    accumulator_next;
  logic               halted;
  logic               halted_next;
  logic               emit;
  logic [CP_W-1:0]    emit_cp;
  status_t            emit_st;
  logic [CP_W-1:0]    shifted;
  logic [CP_W-1:0]    out_cp;
  status_t            out_st;

  // A token is consumed whenever the output register can take a result.
  assign pop     = tok_valid && (!m_tvalid || m_tready);
  assign shifted = {accumulator[CP_W-CONT_BITS-1:0], tok.data[CONT_BITS-1:0]};

  // Decode step for one token.
  always_comb begin
    bytes_left_next  = bytes_left;
    accumulator_next = accumulator;
    halted_next      = halted;
    emit             = 1'b0;
    emit_cp          = '0;
    emit_st          = ST_COMPLETE;
    if (tok.kind == K_TERM) begin
      if (!halted && bytes_left != '0) begin
        emit    = 1'b1;
        emit_cp = accumulator;
        emit_st = ST_TRUNCATED;
      end
      bytes_left_next  = '0;
      accumulator_next = '0;
      halted_next      = 1'b0;
    end else if (halted) begin
      // Bytes after a bad lead are dropped until the terminator.
    end else if (bytes_left != '0) begin
      // Any nonzero byte here counts as a continuation byte.
      bytes_left_next = bytes_left - 1'b1;
      if (bytes_left == BLEFT_W'(1)) begin
        emit             = 1'b1;
        emit_cp          = shifted;
        accumulator_next = '0;
      end else begin
        accumulator_next = shifted;
      end
    end else begin
      unique case (tok.kind)
        K_ASCII: begin
          emit    = 1'b1;
          emit_cp = CP_W'(tok.data);
        end
        K_LEAD2: begin
          accumulator_next = CP_W'(tok.data[4:0]);
          bytes_left_next  = BLEFT_W'(1);
        end
        K_LEAD3: begin
          accumulator_next = CP_W'(tok.data[3:0]);
          bytes_left_next  = BLEFT_W'(2);
        end
        K_LEAD4: begin
          accumulator_next = CP_W'(tok.data[2:0]);
          bytes_left_next  = BLEFT_W'(3);
        end
        default: begin
          accumulator_next = '0;
          halted_next      = 1'b1;
          emit             = 1'b1;
          emit_st          = ST_BAD_LEAD;
        end
      endcase
    end
  end

  // Decoder state.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left  <= '0;
      accumulator <= '0;
      halted      <= 1'b0;
    end else if (pop) begin
      bytes_left  <= bytes_left_next;
      accumulator <= accumulator_next;
      halted      <= halted_next;
    end
  end

  // Output register: loads a new result or drains when the sink takes one.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop && emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_cp <= emit_cp;
      out_st <= emit_st;
    end
  end

  assign m_tdata = OUT_DATA_W'(out_cp);
  assign m_tuser = out_st;

  // A bad lead can only be seen with no sequence open.
  `U8SD_ASSERT_ALWAYS(a_halted_idle, clk, rst, !halted || bytes_left == '0)
  // A bad-lead result always carries a zero code point.
  `U8SD_ASSERT_SAME(a_bad_zero, clk, rst, m_tvalid && out_st == ST_BAD_LEAD, out_cp == '0)
  // A terminator returns the decoder to its reset state.
  `U8SD_ASSERT_NEXT(a_term_clear, clk, rst, pop && tok.kind == K_TERM,
                    bytes_left == '0 && accumulator == '0 && !halted)
  // Nothing is consumed while a result is stalled at the output.
  `U8SD_ASSERT_SAME(a_no_pop_stalled, clk, rst, m_tvalid && !m_tready, !pop)

endmodule

>>> hdl/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder.
//
//   channel  | direction | payload
//   ---------+-----------+--------------------------------------------------
//   s_axis   | in        | tdata[7:0] data_byte
//   m_axis   | out       | tdata[20:0] char_value, tuser[1:0] status
//
// One byte is accepted per cycle while the token queue has room; the back end
// retires one queued token per cycle unless the output is stalled, so with
// the output unstalled the sustained rate is one byte a cycle. A result passes
// through the queue and then the output register before it is presented.
// Reset (rst, synchronous) empties the queue and clears the decoder state. A
// stalled output holds the back end; the front keeps taking bytes until the
// queue of QUEUE_DEPTH tokens fills.
module utf8_stream_decoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [20:0] char_value, [23:21] zero
  output logic [1:0]  m_tuser    // [1:0] status
);
  import u8sd_pkg::*;

  push_t  push;
  logic   q_full;
  logic   q_pop;
  logic   tok_valid;
  token_t tok;

  u8sd_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .push     (push)
  );

  u8sd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (q_full),
    .pop       (q_pop),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

  u8sd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (tok_valid),
    .tok       (tok),
    .pop       (q_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

>>> dv/utf8_stream_decoder_unit_tb.sv
// Self-checking testbench for the UTF-8 stream decoder with a byte-level decode predictor.
module utf8_stream_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u8sd_pkg::*;

  localparam int IDLE_LIMIT  = 2000;
  localparam int LONG_HOLD   = 120;
  localparam int RAND_BYTES  = 1100;
  localparam int DRAIN_WAIT  = 10;

  typedef struct {
    logic [CP_W-1:0] cp;
    status_t         st;
  } cp_result_t;

  typedef struct {
    logic [BYTE_W-1:0] b;
    bit                drain;
    bit                hold;
  } byte_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [1:0]  m_tuser;

  // Stimulus and expectation stores.
  byte_item_t pending[$];
  cp_result_t cp_expect[$];

  // Decoder state mirrored by the predictor.
  logic [BLEFT_W-1:0] dec_left   = '0;
  logic [CP_W-1:0]    dec_acc    = '0;
  bit                 dec_halted = 1'b0;

  bit in_taken  = 1'b0;
  bit out_taken = 1'b0;
  int gap_left   = 0;
  int calm_in    = 0;
  int stall_left = 0;
  int calm_out   = 0;
  int hold_ask   = 0;
  int hold_seen  = 0;
  int idle_cycles   = 0;
  int mismatches    = 0;
  int bytes_taken   = 0;
  int results_seen  = 0;
  int st_count[4]   = '{0, 0, 0, 0};

  utf8_stream_decoder_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // [7:0] data_byte
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // [20:0] char_value, [23:21] zero
    .m_tuser  (m_tuser)    // [1:0] status
  );

  // Clock with a 4 ns period.
  always #2 clk = ~clk;

  // Predicts the result, if any, that one accepted byte produces.
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output cp_result_t r);
    int ones;
    bit emit;
    r.cp = '0;
    r.st = ST_COMPLETE;
    emit = 1'b0;
    ones = 0;
    // A terminator flushes any partial sequence and clears the halt.
    if (b == '0) begin
      if (!dec_halted && dec_left != '0) begin
        r.cp = dec_acc;
        r.st = ST_TRUNCATED;
        emit = 1'b1;
      end
      dec_left = '0;
      dec_acc = '0;
      dec_halted = 1'b0;
      return emit;
    end
    if (dec_halted)
      return 1'b0;
    // Any nonzero byte mid-sequence counts as a continuation byte.
    if (dec_left != '0) begin
      dec_acc = {dec_acc[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
      dec_left = dec_left - 1'b1;
      if (dec_left == '0) begin
        r.cp = dec_acc;
        dec_acc = '0;
        return 1'b1;
      end
      return 1'b0;
    end
    // Lead byte: the run of leading ones picks the sequence length.
    while (ones < 8 && b[7-ones])
      ones++;
    if (ones == 0) begin
      r.cp = CP_W'(b);
      return 1'b1;
    end
    if (ones == 1 || ones > 4) begin
      dec_acc = '0;
      dec_halted = 1'b1;
      r.st = ST_BAD_LEAD;
      return 1'b1;
    end
    dec_acc = CP_W'(b & ((8'd1 << (8 - ones)) - 8'd1));
    dec_left = BLEFT_W'(ones - 1);
    return 1'b0;
  endfunction

  // Byte driver: presents queued bytes with random gaps, pausing for drains on request.
  always @(negedge clk) begin
    byte_item_t it;
    logic nv;
    if (!rst) begin
      nv = s_tvalid;
      if (!s_tvalid || in_taken) begin
        nv = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending.size() != 0 && !(pending[0].drain && cp_expect.size() != 0)) begin
          it = pending.pop_front();
          nv = 1'b1;
          s_tdata <= it.b;
          if (it.hold)
            hold_ask++;
          if (calm_in == 0 && $urandom_range(0, 29) == 0)
            calm_in = $urandom_range(20, 40);
          if (calm_in != 0) begin
            calm_in--;
            gap_left = 0;
          end else begin
            gap_left = $urandom_range(0, 5);
          end
        end
      end
      s_tvalid <= nv;
    end
  end

  // Result receiver: random stall after each transaction, plus long hold-offs on request.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        stall_left = LONG_HOLD;
      end else if (out_taken) begin
        if (calm_out == 0 && $urandom_range(0, 29) == 0)
          calm_out = $urandom_range(20, 40);
        if (calm_out != 0) begin
          calm_out--;
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 5);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: checks each result transaction, then predicts from each accepted byte.
  always @(posedge clk) begin
    cp_result_t want;
    in_taken  <= !rst && s_tvalid && s_tready;
    out_taken <= !rst && m_tvalid && m_tready;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        st_count[m_tuser]++;
        if (cp_expect.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual char_value %h status %0d",
                   $time, m_tdata[CP_W-1:0], m_tuser);
        end else begin
          want = cp_expect.pop_front();
          if (m_tdata[CP_W-1:0] !== want.cp) begin
            mismatches++;
            $display("%0t: char_value mismatch, expected %h actual %h",
                     $time, want.cp, m_tdata[CP_W-1:0]);
          end
          if (m_tuser !== want.st) begin
            mismatches++;
            $display("%0t: status mismatch, expected %0d actual %0d", $time, want.st, m_tuser);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        bytes_taken++;
        if (decode_byte(s_tdata, want))
          cp_expect.insert(cp_expect.size(), want);
      end
      // Watchdog on cycles with no transaction on either side.
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
          $display("utf8_stream_decoder_unit verification failed");
          $finish;
        end
      end
    end
  end

  task automatic add_byte(input logic [7:0] b, input bit drain = 1'b0, input bit hold = 1'b0);
    byte_item_t it;
    it.b = b;
    it.drain = drain;
    it.hold = hold;
    pending.insert(pending.size(), it);
  endtask

  // Stimulus, reset and end of run.
  initial begin
    logic [7:0] str[$];
    int rand_items;
    int str_idx;
    int n_chars;
    int kind;
    int len;
    int ncont;
    bit cut;

    // Directed part: extremes, each sequence length, bad leads, halting and truncation.
    add_byte(8'h00);                                     // terminator while idle
    add_byte(8'h7F);
    add_byte(8'h01);
    add_byte(8'hC3); add_byte(8'hA9);                    // two-byte sequence
    add_byte(8'hE2); add_byte(8'h82); add_byte(8'hAC);   // three-byte sequence
    add_byte(8'hF7, 1'b1); add_byte(8'hBF);              // largest four-byte value
    add_byte(8'hBF); add_byte(8'hBF);
    add_byte(8'h80);                                     // lone continuation as lead
    add_byte(8'h41);                                     // ignored while halted
    add_byte(8'h00);                                     // terminator clears the halt
    add_byte(8'hF8);                                     // five leading ones
    add_byte(8'hFF);                                     // ignored while halted
    add_byte(8'h00);
    add_byte(8'hE2); add_byte(8'h82); add_byte(8'h00);   // terminator mid-sequence
    add_byte(8'hC2); add_byte(8'hFF);                    // continuation bits not checked
    add_byte(8'hFF);                                     // eight leading ones
    add_byte(8'h00);

    // Random strings: mostly well-formed characters, some noise and cut-off sequences.
    rand_items = 0;
    str_idx = 0;
    while (rand_items < RAND_BYTES) begin
      str = {};
      n_chars = $urandom_range(0, 8);
      cut = 1'b0;
      for (int c = 0; c < n_chars && !cut; c++) begin
        kind = $urandom_range(0, 19);
        if (kind < 2) begin
          str.insert(str.size(), 8'($urandom_range(1, 255)));
        end else if (kind < 6) begin
          str.insert(str.size(), 8'($urandom_range(1, 127)));
        end else begin
          len = (kind < 10) ? 2 : (kind < 14) ? 3 : (kind < 18) ? 4 : $urandom_range(2, 4);
          ncont = len - 1;
          if (kind >= 18) begin
            ncont = $urandom_range(0, len - 2);
            cut = 1'b1;
          end
          case (len)
            2: str.insert(str.size(), 8'hC0 | 8'($urandom_range(0, 31)));
            3: str.insert(str.size(), 8'hE0 | 8'($urandom_range(0, 15)));
            default: str.insert(str.size(), 8'hF0 | 8'($urandom_range(0, 7)));
          endcase
          for (int k = 0; k < ncont; k++)
            str.insert(str.size(), 8'h80 | 8'($urandom_range(0, 63)));
        end
      end
      str.insert(str.size(), 8'h00);
      foreach (str[i])
        add_byte(str[i], i == 0 && str_idx % 25 == 7, i == 0 && (str_idx == 20 || str_idx == 120));
      rand_items += str.size();
      str_idx++;
    end

    // Hold reset at the start, then release it at a falling clock edge.
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all bytes to go in and all results to come out.
    while (pending.size() != 0 || s_tvalid)
      @(posedge clk);
    while (cp_expect.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Run covered %0d bytes in %0d strings, %0d results checked.",
             bytes_taken, str_idx, results_seen);
    $display("Results by status: %0d complete, %0d truncated, %0d bad lead.",
             st_count[ST_COMPLETE], st_count[ST_TRUNCATED], st_count[ST_BAD_LEAD]);
    if (mismatches == 0 && cp_expect.size() == 0) begin
      $display("utf8_stream_decoder_unit verification clean");
    end else begin
      $display("utf8_stream_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
